// ----- hdl/pss_pkg.sv -----
// ============================================================================
// pss_pkg: shared types and constants for the PSS1A stabilizer
// Holds the payload structs, fixed-point constants and datapath commands.
// ============================================================================
package pss_pkg;

  localparam int unsigned DW = 24;
  localparam int unsigned FB = 18;

  // One input word.
  typedef struct packed {
    logic signed [DW-1:0] speed_dev;
    logic signed [DW-1:0] active_power;
    logic signed [DW-1:0] volt_d;
    logic signed [DW-1:0] volt_q;
    logic                 load_init;
  } pss_in_t;

  // One result word.
  typedef struct packed {
    logic signed [DW-1:0] stabilizer_out;
    logic [1:0]           limit_hit;
  } pss_out_t;

  localparam logic [1:0] LIMIT_NONE  = 2'd0;
  localparam logic [1:0] LIMIT_UPPER = 2'd1;
  localparam logic [1:0] LIMIT_LOWER = 2'd2;

  localparam logic [2:0] REG_KW    = 3'd0;
  localparam logic [2:0] REG_KP    = 3'd1;
  localparam logic [2:0] REG_KV    = 3'd2;
  localparam logic [2:0] REG_R1    = 3'd3;
  localparam logic [2:0] REG_R2    = 3'd4;
  localparam logic [2:0] REG_TW    = 3'd5;
  localparam logic [2:0] REG_STEPS = 3'd6;
  localparam logic [2:0] REG_LIMS  = 3'd7;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONEV = DW'(1) << FB;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,     // latch input word, clear root
    OP_SQRT,     // one root bit
    OP_MAG,      // store magnitude
    OP_SUMC,     // start current sum with Kw*speed
    OP_SUMC2,    // add Kp*power
    OP_SUMC3,    // add Kv*mag
    OP_SUML,     // previous sum, three steps
    OP_SUML2,
    OP_SUML3,
    OP_U,        // u = S + washout
    OP_Y1,       // y1 = lead1 + r1*u
    OP_NW,       // nw = washout - tw*u
    OP_AU,       // t = A*u - lead1
    OP_N1,       // n1 = lead1 + s2*t
    OP_BY,       // t = B*y1 - lead2
    OP_N2,       // n2 = lead2 + s4*t
    OP_COMMIT,   // states take new values, uc
    OP_YC,       // yc = lead1 + r1*uc
    OP_VS,       // vs = lead2 + r2*yc, clamp
    OP_INIT      // steady state load
  } pss_op_e;

  typedef struct packed {
    pss_op_e     op;
    logic [4:0]  bit_idx;
  } pss_cmd_t;

  // Saturate a wide value to DW bits.
  function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] x);
    logic signed [DW-1:0] r;
    if (x > (DW+2)'(MAXV)) r = MAXV;
    else if (x < (DW+2)'(MINV)) r = MINV;
    else r = x[DW-1:0];
    return r;
  endfunction

  // Fixed-point product, floor shift then saturate.
  function automatic logic signed [DW-1:0] fmul(input logic signed [DW:0] a,
                                                input logic signed [DW:0] b);
    logic signed [2*DW+1:0] p;
    logic signed [2*DW+1:0] s;
    logic signed [DW-1:0]   r;
    p = a * b;
    s = p >>> FB;
    if (s > (2*DW+2)'(MAXV)) r = MAXV;
    else if (s < (2*DW+2)'(MINV)) r = MINV;
    else r = s[DW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/power_system_stabilizer_pss1a.sv -----
// ============================================================================
// power_system_stabilizer_pss1a: PSS1A stabilizer top level
// Register file and the sequencer and datapath of the stabilizer.
// ============================================================================
//  channel | direction | handshake
//  input   | in        | in_valid_i / in_ready_o, word in_data_i
//  output  | out       | out_valid_o / out_ready_i, word out_data_o
//  config  | in        | APB write and read, 8-byte registers
//
// The word is latched at the accepting edge; no new word is taken until its
// result is valid: a 24-step root, then the shared multiplier serially through
// the sums and filter update (an init word loads the steady state instead).
// Reset clears filter states, result and registers; limits go to full range.
// A result waiting in the output register is held; the next word is taken while
// it waits, and its last step stalls until that one leaves.
module power_system_stabilizer_pss1a import pss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pss_in_t       in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pss_out_t      out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [63:0] regs_q [8];
  logic [2:0]  idx;
  pss_cmd_t    cmd;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= (i == int'(REG_LIMS)) ? 64'({MAXV, MINV}) : 64'd0;
      end
    end else if (psel && penable && pwrite) begin
      regs_q[idx] <= pwdata;
    end
  end

  pss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .init_i(in_data_i.load_init), .out_valid_o, .out_ready_i, .cmd_o(cmd)
  );

  pss_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i),
    .kw_i(regs_q[REG_KW][DW-1:0]), .kp_i(regs_q[REG_KP][DW-1:0]),
    .kv_i(regs_q[REG_KV][DW-1:0]), .r1_i(regs_q[REG_R1][DW-1:0]),
    .r2_i(regs_q[REG_R2][DW-1:0]), .tw_i(regs_q[REG_TW][DW-2:0]),
    .steps_i(regs_q[REG_STEPS][2*DW-1:0]), .lims_i(regs_q[REG_LIMS][2*DW-1:0]),
    .res_o(out_data_o)
  );

endmodule

// ----- hdl/pss_datapath.sv -----
// ============================================================================
// pss_datapath: arithmetic and state of the stabilizer
// One shared multiplier, a bit-serial square root and the filter states.
// ============================================================================
module pss_datapath import pss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pss_cmd_t          cmd_i,
  input  pss_in_t           in_i,
  input  logic [DW-1:0]     kw_i,
  input  logic [DW-1:0]     kp_i,
  input  logic [DW-1:0]     kv_i,
  input  logic [DW-1:0]     r1_i,
  input  logic [DW-1:0]     r2_i,
  input  logic [DW-2:0]     tw_i,
  input  logic [2*DW-1:0]   steps_i,
  input  logic [2*DW-1:0]   lims_i,
  output pss_out_t          res_o
);

  logic signed [DW-1:0] sp_q, pw_q;
  logic [2*DW+1:0]      sq_q;
  logic [DW-1:0]        root_q, root_d;
  logic signed [DW-1:0] wash_q, l1_q, l2_q, ls_q, lp_q, lm_q, mag_q;
  logic signed [DW-1:0] cur_q, prev_q, u_q, y1_q, nw_q, n1_q, n2_q, t_q, uc_q;
  pss_out_t             res_q;

  logic [DW-1:0]        cand;
  logic [2*DW-1:0]      csq;
  logic signed [DW:0]   ma, mb;
  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] vs;
  logic signed [DW-1:0] a_fac, b_fac;
  logic signed [DW:0]   vd_x, vq_x;
  logic [DW:0]          abs_d, abs_q;
  logic [2*DW+1:0]      sq_sum;

  // Sum of squares of the voltage components of the incoming word.
  always_comb begin
    vd_x   = {in_i.volt_d[DW-1], in_i.volt_d};
    vq_x   = {in_i.volt_q[DW-1], in_i.volt_q};
    abs_d  = vd_x[DW] ? $unsigned(-vd_x) : $unsigned(vd_x);
    abs_q  = vq_x[DW] ? $unsigned(-vq_x) : $unsigned(vq_x);
    sq_sum = (2*DW+2)'(abs_d) * (2*DW+2)'(abs_d)
           + (2*DW+2)'(abs_q) * (2*DW+2)'(abs_q);
  end

  // One root bit a step: try the bit, keep it if its square fits.
  always_comb begin
    cand   = root_q | (DW'(1) << cmd_i.bit_idx);
    csq    = cand * cand;
    root_d = ({2'b00, csq} <= sq_q) ? cand : root_q;
  end

  // Lead factors one minus the time constant ratio.
  assign a_fac = sat((DW+2)'(ONEV) - (DW+2)'($signed(r1_i)));
  assign b_fac = sat((DW+2)'(ONEV) - (DW+2)'($signed(r2_i)));

  // Shared multiplier operand select.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_SUMC:  begin ma = {kw_i[DW-1], kw_i}; mb = {sp_q[DW-1], sp_q}; end
      OP_SUMC2: begin ma = {kp_i[DW-1], kp_i}; mb = {pw_q[DW-1], pw_q}; end
      OP_SUMC3: begin ma = {kv_i[DW-1], kv_i}; mb = {mag_q[DW-1], mag_q}; end
      OP_SUML:  begin ma = {kw_i[DW-1], kw_i}; mb = {ls_q[DW-1], ls_q}; end
      OP_SUML2: begin ma = {kp_i[DW-1], kp_i}; mb = {lp_q[DW-1], lp_q}; end
      OP_SUML3: begin ma = {kv_i[DW-1], kv_i}; mb = {lm_q[DW-1], lm_q}; end
      OP_Y1:    begin ma = {r1_i[DW-1], r1_i}; mb = {u_q[DW-1], u_q}; end
      OP_NW:    begin ma = {2'b00, tw_i};      mb = {u_q[DW-1], u_q}; end
      OP_AU:    begin ma = {a_fac[DW-1], a_fac}; mb = {u_q[DW-1], u_q}; end
      OP_N1:    begin ma = {1'b0, steps_i[2*DW-1:DW]}; mb = {t_q[DW-1], t_q}; end
      OP_BY:    begin ma = {b_fac[DW-1], b_fac}; mb = {y1_q[DW-1], y1_q}; end
      OP_N2:    begin ma = {1'b0, steps_i[DW-1:0]}; mb = {t_q[DW-1], t_q}; end
      OP_YC:    begin ma = {r1_i[DW-1], r1_i}; mb = {uc_q[DW-1], uc_q}; end
      OP_VS:    begin ma = {r2_i[DW-1], r2_i}; mb = {y1_q[DW-1], y1_q}; end
      default:  begin ma = '0; mb = '0; end
    endcase
    prod = fmul(ma, mb);
  end

  assign vs = sat((DW+2)'(l2_q) + (DW+2)'(prod));

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sp_q   <= in_i.speed_dev;
        pw_q   <= in_i.active_power;
        sq_q   <= sq_sum;
        root_q <= '0;
      end
      OP_SQRT:  root_q <= root_d;
      OP_MAG:   mag_q  <= root_q[DW-1] ? MAXV : root_q;
      OP_SUMC:  cur_q  <= prod;
      OP_SUMC2: cur_q  <= sat((DW+2)'(cur_q) + (DW+2)'(prod));
      OP_SUMC3: cur_q  <= sat((DW+2)'(cur_q) + (DW+2)'(prod));
      OP_SUML:  prev_q <= prod;
      OP_SUML2: prev_q <= sat((DW+2)'(prev_q) + (DW+2)'(prod));
      OP_SUML3: prev_q <= sat((DW+2)'(prev_q) + (DW+2)'(prod));
      OP_U:     u_q    <= sat((DW+2)'(prev_q) + (DW+2)'(wash_q));
      OP_Y1:    y1_q   <= sat((DW+2)'(l1_q) + (DW+2)'(prod));
      OP_NW:    nw_q   <= sat((DW+2)'(wash_q) - (DW+2)'(prod));
      OP_AU:    t_q    <= sat((DW+2)'(prod) - (DW+2)'(l1_q));
      OP_N1:    n1_q   <= sat((DW+2)'(l1_q) + (DW+2)'(prod));
      OP_BY:    t_q    <= sat((DW+2)'(prod) - (DW+2)'(l2_q));
      OP_N2:    n2_q   <= sat((DW+2)'(l2_q) + (DW+2)'(prod));
      OP_COMMIT: uc_q  <= sat((DW+2)'(cur_q) + (DW+2)'(nw_q));
      OP_YC:    y1_q   <= sat((DW+2)'(l1_q) + (DW+2)'(prod));
      default: ;
    endcase
  end

  // Filter states, last-sample memory and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wash_q <= '0; l1_q <= '0; l2_q <= '0;
      ls_q <= '0; lp_q <= '0; lm_q <= '0;
      res_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_COMMIT: begin
          wash_q <= nw_q; l1_q <= n1_q; l2_q <= n2_q;
        end
        OP_VS: begin
          ls_q <= sp_q; lp_q <= pw_q; lm_q <= mag_q;
          if (vs > $signed(lims_i[2*DW-1:DW])) begin
            res_q <= '{stabilizer_out: lims_i[2*DW-1:DW], limit_hit: LIMIT_UPPER};
          end else if (vs < $signed(lims_i[DW-1:0])) begin
            res_q <= '{stabilizer_out: lims_i[DW-1:0], limit_hit: LIMIT_LOWER};
          end else begin
            res_q <= '{stabilizer_out: vs, limit_hit: LIMIT_NONE};
          end
        end
        OP_INIT: begin
          wash_q <= sat(-(DW+2)'(cur_q)); l1_q <= '0; l2_q <= '0;
          ls_q <= sp_q; lp_q <= pw_q; lm_q <= mag_q;
          res_q <= '{stabilizer_out: '0, limit_hit: LIMIT_NONE};
        end
        default: ;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/pss_ctrl.sv -----
// ============================================================================
// pss_ctrl: sequencer for the stabilizer
// Steps the datapath through root, sums, filter update and output.
// ============================================================================
module pss_ctrl import pss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     init_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pss_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e     state_q;
  pss_op_e    op_q;
  logic [4:0] bit_q;
  logic       init_q;
  logic       out_valid_q;
  logic       stall;

  // The step that writes the result waits while an older result is held.
  assign stall = out_valid_q && !out_ready_i && (op_q == OP_VS || op_q == OP_INIT);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // The word is latched at the accepting edge; later steps follow op_q.
  always_comb begin
    cmd_o.bit_idx = bit_q;
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NOP;
      S_RUN:   cmd_o.op = stall ? OP_NOP : op_q;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  // Sequence state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= OP_NOP; bit_q <= '0;
      init_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN; op_q <= OP_SQRT; bit_q <= 5'(DW-1); init_q <= init_i;
          end
        end
        S_RUN: begin
          case (op_q)
            OP_SQRT: begin
              if (bit_q == '0) op_q <= OP_MAG;
              else bit_q <= bit_q - 5'd1;
            end
            OP_MAG:   op_q <= OP_SUMC;
            OP_SUMC:  op_q <= OP_SUMC2;
            OP_SUMC2: op_q <= OP_SUMC3;
            OP_SUMC3: op_q <= init_q ? OP_INIT : OP_SUML;
            OP_SUML:  op_q <= OP_SUML2;
            OP_SUML2: op_q <= OP_SUML3;
            OP_SUML3: op_q <= OP_U;
            OP_U:     op_q <= OP_Y1;
            OP_Y1:    op_q <= OP_NW;
            OP_NW:    op_q <= OP_AU;
            OP_AU:    op_q <= OP_N1;
            OP_N1:    op_q <= OP_BY;
            OP_BY:    op_q <= OP_N2;
            OP_N2:    op_q <= OP_COMMIT;
            OP_COMMIT: op_q <= OP_YC;
            OP_YC:    op_q <= OP_VS;
            default: begin
              if (!stall) state_q <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          out_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
